[hw/rtl/chkv_pkg.sv]
`default_nettype none
package chkv_pkg;
  localparam int unsigned BucketsDefault  = 256;
  localparam int unsigned CapacityDefault = 1024;

  localparam logic [1:0] KindInsert = 2'd0;
  localparam logic [1:0] KindLookup = 2'd1;
  localparam logic [1:0] KindRemove = 2'd2;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusMissing = 2'd1;
  localparam logic [1:0] StatusFull    = 2'd2;
endpackage
`default_nettype wire

[hw/rtl/chained_hash_key_value_table.sv]
// Sequencing: an insert word reads the bucket head and writes a new entry, which may come
// from the free list; when the pool is full no entry is written, and a word of unknown kind
// goes straight to its result. A lookup or remove walks the bucket's chain entry by entry,
// and each visit reads the entry memory and compares the key.
// Throughput: one word at a time; the next word is taken once the result has been accepted.
// Reset: asynchronous, active low; a clearing pass then empties one bucket per cycle over
// all BUCKETS buckets, while no input word is accepted.
`default_nettype none
module chained_hash_key_value_table #(
  parameter int unsigned BUCKETS  = chkv_pkg::BucketsDefault,
  parameter int unsigned CAPACITY = chkv_pkg::CapacityDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // Fields from bit 0: key (64 bits), value (32 bits).
  input  wire logic [95:0]  s_axis_tdata,
  // Fields from bit 0: kind (2 bits).
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // Fields from bit 0: status (2 bits), found_value (32 bits), zero fill.
  output logic [39:0]       m_axis_tdata
);
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IW-1:0] Nil = IW'(CAPACITY);
  localparam logic [IW-1:0] CapMark = IW'(CAPACITY);

  typedef enum logic [3:0] {
    StClear, StIdle, StHead, StHeadWait, StAlloc, StAllocWait, StWrite,
    StRead, StReadWait, StCheck, StUnlink, StOut
  } state_e;

  logic [IW-1:0] head_mem [BUCKETS];
  logic [63:0]   key_mem  [CAPACITY];
  logic [31:0]   val_mem  [CAPACITY];
  logic [IW-1:0] next_mem [CAPACITY];

  state_e        state_q;
  logic [1:0]    kind_q;
  logic [63:0]   key_q;
  logic [31:0]   value_q;
  logic [BW-1:0] bkt_q;
  logic [IW-1:0] cur_q, prev_q, free_q, mark_q, steps_q;
  logic [IW-1:0] head_rd_q, next_rd_q;
  logic [63:0]   key_rd_q;
  logic [31:0]   val_rd_q;
  logic [1:0]    status_q;
  logic [31:0]   found_q;
  logic          out_valid_q;

  wire logic [BW-1:0] in_bkt = s_axis_tdata[BW-1:0];
  wire logic [AW-1:0] cur_a = cur_q[AW-1:0];

  assign s_axis_tready = (state_q == StIdle) && !out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, found_q, status_q};

  // Memory ports: all reads registered.
  always_ff @(posedge clk_i) begin
    head_rd_q <= head_mem[bkt_q];
    key_rd_q  <= key_mem[cur_a];
    val_rd_q  <= val_mem[cur_a];
    next_rd_q <= next_mem[cur_a];
    if (state_q == StClear) begin
      head_mem[bkt_q] <= Nil;
    end else if (state_q == StWrite) begin
      head_mem[bkt_q] <= cur_q;
    end else if (state_q == StUnlink && prev_q == Nil) begin
      head_mem[bkt_q] <= next_rd_q;
    end
    if (state_q == StWrite) begin
      key_mem[cur_a]  <= key_q;
      val_mem[cur_a]  <= value_q;
      next_mem[cur_a] <= head_rd_q;
    end else if (state_q == StUnlink) begin
      next_mem[cur_a] <= free_q;
    end else if (state_q == StCheck && kind_q == chkv_pkg::KindRemove && prev_q != Nil
                 && key_rd_q == key_q) begin
      next_mem[prev_q[AW-1:0]] <= next_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      bkt_q       <= '0;
      free_q      <= Nil;
      mark_q      <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= '0;
      key_q       <= '0;
      value_q     <= '0;
      cur_q       <= Nil;
      prev_q      <= Nil;
      steps_q     <= '0;
      status_q    <= '0;
      found_q     <= '0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          bkt_q <= bkt_q + 1'b1;
          if (bkt_q == BW'(BUCKETS - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            kind_q   <= s_axis_tuser;
            key_q    <= s_axis_tdata[63:0];
            value_q  <= s_axis_tdata[95:64];
            bkt_q    <= in_bkt;
            status_q <= chkv_pkg::StatusMissing;
            found_q  <= '0;
            prev_q   <= Nil;
            steps_q  <= '0;
            cur_q    <= free_q;
            if (s_axis_tuser == chkv_pkg::KindInsert || s_axis_tuser == chkv_pkg::KindLookup
                || s_axis_tuser == chkv_pkg::KindRemove) begin
              state_q <= StHead;
            end else begin
              state_q <= StOut;
            end
          end
        end
        StHead: state_q <= StHeadWait;
        StHeadWait: begin
          if (kind_q == chkv_pkg::KindInsert) begin
            state_q <= StAlloc;
          end else begin
            cur_q   <= head_rd_q;
            state_q <= StRead;
          end
        end
        StAlloc: begin
          if (free_q != Nil) begin
            state_q <= StAllocWait;
          end else if (mark_q != CapMark) begin
            cur_q   <= mark_q;
            mark_q  <= mark_q + 1'b1;
            state_q <= StWrite;
          end else begin
            status_q <= chkv_pkg::StatusFull;
            state_q  <= StOut;
          end
        end
        StAllocWait: begin
          free_q  <= next_rd_q;
          state_q <= StWrite;
        end
        StWrite: begin
          status_q <= chkv_pkg::StatusOk;
          state_q  <= StOut;
        end
        StRead: begin
          if (cur_q >= CapMark || steps_q == CapMark) begin
            state_q <= StOut;
          end else begin
            state_q <= StReadWait;
          end
        end
        StReadWait: state_q <= StCheck;
        StCheck: begin
          if (key_rd_q == key_q) begin
            status_q <= chkv_pkg::StatusOk;
            if (kind_q == chkv_pkg::KindLookup) begin
              found_q <= val_rd_q;
              state_q <= StOut;
            end else begin
              state_q <= StUnlink;
            end
          end else begin
            prev_q  <= cur_q;
            cur_q   <= next_rd_q;
            steps_q <= steps_q + 1'b1;
            state_q <= StRead;
          end
        end
        StUnlink: begin
          free_q  <= cur_q;
          state_q <= StOut;
        end
        StOut: begin
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/chkv_checker.sv]
`default_nettype none
module chkv_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
  a_accept_drops_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after accept");
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3)) else $error("bad status");
  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] != 2'd0) |-> (m_axis_tdata[33:2] == 32'd0))
    else $error("value on failure");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped");
endmodule

bind chained_hash_key_value_table chkv_checker u_chkv_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
